// ===== hw/rtl/ffca_pkg.sv =====
// ffca_pkg: shared types and codes for the first-fit coalescing allocator.
// No dependencies.
package ffca_pkg;

	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_NO_FIT   = 2'd1;
	localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

	localparam logic KIND_ALLOC = 1'b0;
	localparam logic KIND_FREE  = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOOK,
		ST_DECIDE,
		ST_SHIFT,
		ST_OUT
	} state_t;

	// Broadcast command from the sequencer to every cell.
	typedef enum logic [2:0] {
		OP_HOLD,
		OP_WRITE,
		OP_SHIFT_DOWN,
		OP_SHIFT_UP
	} cell_op_t;

endpackage

// ===== hw/rtl/ffca_cell.sv =====
// ffca_cell: one free-range slot (start, size) of the sorted range chain.
// Depends on ffca_pkg.
module ffca_cell #(
	parameter int AW = 12,
	parameter int SW = 13
) (
	input  logic                 clk,
	input  ffca_pkg::cell_op_t   op,
	input  logic                 sel,
	input  logic                 shift_en,
	input  logic [AW-1:0]        wr_start,
	input  logic [SW-1:0]        wr_size,
	input  logic [AW-1:0]        up_start,
	input  logic [SW-1:0]        up_size,
	input  logic [AW-1:0]        dn_start,
	input  logic [SW-1:0]        dn_size,
	input  logic                 init_en,
	input  logic [AW-1:0]        init_start,
	input  logic [SW-1:0]        init_size,
	output logic [AW-1:0]        start_q,
	output logic [SW-1:0]        size_q
);
	import ffca_pkg::*;

	// Shift down: take the neighbor below (higher index) to close a gap.
	// Shift up: take the neighbor above (lower index) to open a gap.
	always_ff @(posedge clk) begin
		if (init_en) begin
			start_q <= init_start;
			size_q  <= init_size;
		end else begin
			unique case (op)
				OP_WRITE: if (sel) begin
					start_q <= wr_start;
					size_q  <= wr_size;
				end
				OP_SHIFT_DOWN: if (shift_en) begin
					start_q <= dn_start;
					size_q  <= dn_size;
				end
				OP_SHIFT_UP: if (shift_en) begin
					start_q <= up_start;
					size_q  <= up_size;
				end
				default: ;
			endcase
		end
	end
endmodule

// ===== hw/rtl/first_fit_coalescing_allocator.sv =====
// first_fit_coalescing_allocator: top level, sequencer over a chain of range cells
// plus the block-size memory. Depends on ffca_pkg and ffca_cell.
//
// Usage: requests enter on s_axis (tuser = kind, tdata = request_bytes and
// block_address); each request yields exactly one result on m_axis (status and
// payload_address). A free of a never-allocated address reads an unwritten
// size entry and is undefined.
// Timing: one request at a time. The sequencer scans the chain one cell per
// cycle from index 0 up to p, the index of the fitting range (alloc) or of the
// insert point (free). A decide step follows, plus a shift step when a free
// inserts a range or merges on both sides, and then the result is valid. A
// failed alloc scans every range and then goes straight to the result; an
// ignored free goes straight from the look state to the result. s_tready
// returns once the sequencer is back in idle after the result is taken. In a
// table shift, every cell from the shift point onward copies its neighbor.
// Reset: arst_n clears control; the chain holds one free range covering the heap
// minus a header. The size memory needs no clearing.
// Stall: the result waits in the output register while m_tready is low; a new
// request is not taken until the result has left.
module first_fit_coalescing_allocator #(
	parameter int HEAP_BYTES      = 4096,
	parameter int ALIGN_BYTES     = 8,
	parameter int HEADER_BYTES    = 24,
	parameter int MAX_FREE_RANGES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // [12:0] request_bytes, [24:13] block_address
	input  logic        s_tuser,  // [0] kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata   // [1:0] status, [13:2] payload_address
);
	import ffca_pkg::*;

	localparam int AW = 12;
	localparam int RW = 13; // range starts can pass the heap end after overlapping frees
	localparam int SW = 13;
	localparam int N  = MAX_FREE_RANGES;
	localparam int IW = (N > 1) ? $clog2(N) : 1;
	localparam int CW = $clog2(N + 1);
	localparam int DEPTH = HEAP_BYTES / ALIGN_BYTES;
	localparam int DW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int ALB = $clog2(ALIGN_BYTES);
	localparam int XW = 24; // wide enough for heap-sized sums

	// chain
	logic [RW-1:0] st_q [N];
	logic [SW-1:0] sz_q [N];
	cell_op_t      op;
	logic [N-1:0]  sel, shen;
	logic [RW-1:0] wr_start;
	logic [SW-1:0] wr_size;
	logic          init_q;

	// control
	state_t        state_q, state_d;
	logic [CW-1:0] count_q;
	logic [CW-1:0] p_q;
	logic          kind_q;
	logic [XW-1:0] need_q, h_q, s_q;
	logic [DW-1:0] idx_q;
	logic          ign_q;
	logic          dbl_q;
	logic [1:0]    status_q;
	logic [AW-1:0] paddr_q;
	logic          outv_q;

	// size memory
	logic [SW-1:0] mem [DEPTH];
	logic [SW-1:0] mem_rd_q;
	logic          mem_we;
	logic [DW-1:0] mem_wa;
	logic [SW-1:0] mem_wd;

	logic          take_in;
	logic [12:0]   req_in;
	logic [11:0]   addr_in;

	// read the freed block's size as soon as the request is taken
	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
		mem_rd_q <= mem[take_in ? DW'(addr_in >> ALB) : idx_q];
	end

	genvar g;
	generate
		for (g = 0; g < N; g++) begin : g_cell
			logic [RW-1:0] us, ds;
			logic [SW-1:0] uz, dz;
			if (g == 0) begin : g_f
				assign us = '0; assign uz = '0;
			end else begin : g_u
				assign us = st_q[g-1]; assign uz = sz_q[g-1];
			end
			if (g == N-1) begin : g_l
				assign ds = '0; assign dz = '0;
			end else begin : g_d
				assign ds = st_q[g+1]; assign dz = sz_q[g+1];
			end
			ffca_cell #(.AW(RW), .SW(SW)) u_cell (
				.clk(clk), .op(op), .sel(sel[g]), .shift_en(shen[g]),
				.wr_start(wr_start), .wr_size(wr_size),
				.up_start(us), .up_size(uz), .dn_start(ds), .dn_size(dz),
				.init_en(init_q),
				.init_start(RW'(0)), .init_size(SW'(HEAP_BYTES - HEADER_BYTES)),
				.start_q(st_q[g]), .size_q(sz_q[g]));
		end
	endgenerate

	// scanned cell (p) and its predecessor
	logic [IW-1:0] pi, pm;
	logic [XW-1:0] cur_st, cur_sz, prv_st, prv_sz;
	assign pi = p_q[IW-1:0];
	assign pm = IW'(p_q - CW'(1));
	assign cur_st = XW'(st_q[pi]);
	assign cur_sz = XW'(sz_q[pi]);
	assign prv_st = XW'(st_q[pm]);
	assign prv_sz = XW'(sz_q[pm]);

	logic in_range;
	assign in_range = (p_q < count_q);

	function automatic logic [XW-1:0] sat(input logic [XW-1:0] x);
		return (x > XW'(HEAP_BYTES)) ? XW'(HEAP_BYTES) : x;
	endfunction

	assign s_tready = (state_q == ST_IDLE) && !init_q;
	assign take_in  = s_tvalid && s_tready;
	assign req_in   = s_tdata[12:0];
	assign addr_in  = s_tdata[24:13];

	logic jp, jn;
	assign jp = (p_q != '0) && ((prv_st + prv_sz) == h_q);
	assign jn = in_range && ((h_q + s_q) == cur_st);

	// decide outputs of free
	logic [1:0] dec_kind; // 0 none,1 both,2 prev,3 next
	logic       dec_ins;

	always_comb begin
		state_d = state_q;
		op = OP_HOLD; sel = '0; shen = '0;
		wr_start = '0; wr_size = '0;
		mem_we = 1'b0; mem_wa = idx_q; mem_wd = '0;
		dec_kind = 2'd0; dec_ins = 1'b0;
		unique case (state_q)
			ST_IDLE: if (take_in) state_d = ST_LOOK;
			ST_LOOK: begin
				if (kind_q == KIND_ALLOC) begin
					if (!in_range) state_d = ST_OUT;
					else if (cur_sz >= need_q) state_d = ST_DECIDE;
				end else begin
					if (ign_q) state_d = ST_OUT;
					else if (!in_range || cur_st >= h_q) state_d = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				state_d = ST_OUT;
				if (kind_q == KIND_ALLOC) begin
					// payload index past the store: size not recorded
					mem_we = !ign_q;
					if (cur_sz >= need_q + XW'(HEADER_BYTES)) begin
						op = OP_WRITE; sel[pi] = 1'b1;
						wr_start = RW'(cur_st + need_q);
						wr_size  = SW'(cur_sz - need_q);
						mem_wd = SW'(need_q);
					end else begin
						mem_wd = SW'(cur_sz);
						op = OP_SHIFT_DOWN;
						for (int k = 0; k < N; k++)
							shen[k] = (k >= int'(p_q));
					end
				end else if (jp && jn) begin
					dec_kind = 2'd1;
					state_d = ST_SHIFT;
					op = OP_WRITE; sel[pm] = 1'b1;
					wr_start = RW'(prv_st);
					wr_size = SW'(sat(prv_sz + s_q + cur_sz));
				end else if (jp) begin
					dec_kind = 2'd2;
					op = OP_WRITE; sel[pm] = 1'b1;
					wr_start = RW'(prv_st);
					wr_size = SW'(sat(prv_sz + s_q));
				end else if (jn) begin
					dec_kind = 2'd3;
					op = OP_WRITE; sel[pi] = 1'b1;
					wr_start = RW'(h_q);
					wr_size = SW'(sat(s_q + cur_sz));
				end else if (count_q < CW'(N)) begin
					dec_ins = 1'b1;
					state_d = ST_SHIFT;
					op = OP_SHIFT_UP;
					for (int k = 0; k < N; k++)
						shen[k] = (k > int'(p_q));
				end
			end
			ST_SHIFT: begin
				state_d = ST_OUT;
				if (!dbl_q) begin
					// finish insert: write new range into the opened slot
					op = OP_WRITE; sel[pi] = 1'b1;
					wr_start = RW'(h_q);
					wr_size = SW'(sat(s_q));
				end else begin
					// finish double merge: drop cell p
					op = OP_SHIFT_DOWN;
					for (int k = 0; k < N; k++)
						shen[k] = (k >= int'(p_q));
				end
			end
			ST_OUT: if (!outv_q) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			init_q <= 1'b1;
			count_q <= CW'(1);
			outv_q <= 1'b0;
			p_q <= '0;
			kind_q <= KIND_ALLOC;
			status_q <= STATUS_OK;
			paddr_q <= '0;
			need_q <= '0;
			h_q <= '0;
			s_q <= '0;
			idx_q <= '0;
			ign_q <= 1'b0;
			dbl_q <= 1'b0;
		end else begin
			init_q <= 1'b0;
			state_q <= state_d;
			if (outv_q && m_tready) outv_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: if (take_in) begin
					kind_q <= s_tuser;
					p_q <= '0;
					status_q <= STATUS_OK;
					paddr_q <= '0;
					need_q <= XW'(HEADER_BYTES) +
						((XW'(req_in) + XW'(ALIGN_BYTES - 1)) >> ALB << ALB);
					h_q <= XW'(addr_in) - XW'(HEADER_BYTES);
					idx_q <= DW'(addr_in >> ALB);
					ign_q <= (XW'(addr_in) < XW'(HEADER_BYTES)) ||
						((XW'(addr_in) >> ALB) >= XW'(DEPTH));
				end
				ST_LOOK: begin
					s_q <= XW'(mem_rd_q);
					if (kind_q == KIND_ALLOC) begin
						if (!in_range) status_q <= STATUS_NO_FIT;
						else if (cur_sz >= need_q) begin
							paddr_q <= AW'(cur_st + XW'(HEADER_BYTES));
							idx_q <= DW'((cur_st + XW'(HEADER_BYTES)) >> ALB);
							ign_q <= ((cur_st + XW'(HEADER_BYTES)) >> ALB) >= XW'(DEPTH);
						end else p_q <= p_q + CW'(1);
					end else if (!ign_q && in_range && cur_st < h_q)
						p_q <= p_q + CW'(1);
				end
				ST_DECIDE: begin
					dbl_q <= (kind_q == KIND_FREE) && (dec_kind == 2'd1);
					if (kind_q == KIND_ALLOC) begin
						if (!(cur_sz >= need_q + XW'(HEADER_BYTES)))
							count_q <= count_q - CW'(1);
					end else if (dec_kind == 2'd0) begin
						if (dec_ins) count_q <= count_q + CW'(1);
						else status_q <= STATUS_OVERFLOW;
					end
				end
				ST_SHIFT: if (dbl_q)
					count_q <= count_q - CW'(1);
				default: ;
			endcase
			if (state_d == ST_OUT && state_q != ST_OUT) outv_q <= 1'b1;
		end
	end

	assign m_tvalid = outv_q;
	assign m_tdata  = {2'b00, paddr_q, status_q};
endmodule
